/* hw/rtl/crp_ths_pkg.sv */
`default_nettype none

package crp_ths_pkg;

    // fixed field widths
    localparam int DRAW_BITS = 28;
    localparam int DISC_BITS = 12;
    localparam int OP_BITS   = 2;

    // op codes
    localparam logic [OP_BITS-1:0] OP_SEAT   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_OPEN   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

    // parameter defaults
    localparam int DEF_MAX_SIZE   = 1024;
    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_FRAC_BITS  = 12;

    // register port
    localparam int APB_DATA_BITS = 32;
    localparam int PADDR_BITS    = 2;
    localparam int REG_DISCOUNT  = 0;

    // walk start request
    typedef struct packed {
        logic start;
        logic seat;
    } t_walk_ctl;

    // walk completion status
    typedef struct packed {
        logic done;
        logic found;
    } t_walk_sts;

endpackage

`default_nettype wire

/* hw/rtl/crp_ths_ram.sv */
`default_nettype none

module crp_ths_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/crp_ths_walk.sv */
`default_nettype none

module crp_ths_walk #(
    parameter int MAX_SIZE   = crp_ths_pkg::DEF_MAX_SIZE,
    parameter int COUNT_BITS = crp_ths_pkg::DEF_COUNT_BITS,
    parameter int FRAC_BITS  = crp_ths_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [crp_ths_pkg::DISC_BITS-1:0]   i_disc,
    input  wire crp_ths_pkg::t_walk_ctl              i_ctl,
    input  wire logic [crp_ths_pkg::DRAW_BITS-1:0]   i_r,
    output logic                                     o_rd_en,
    output logic      [$clog2(MAX_SIZE)-1:0]         o_rd_addr,
    input  wire logic [COUNT_BITS-1:0]               i_rd_data,
    output crp_ths_pkg::t_walk_sts                   o_sts,
    output logic      [$clog2(MAX_SIZE)-1:0]         o_idx,
    output logic      [COUNT_BITS-1:0]               o_cnt
);
    import crp_ths_pkg::*;

    localparam int IDX_BITS  = $clog2(MAX_SIZE);
    localparam int SIZE_BITS = $clog2(MAX_SIZE + 1);
    localparam int W_BITS    = SIZE_BITS + FRAC_BITS;
    localparam int CL_BITS   = DRAW_BITS + 1;
    localparam int P_BITS    = 2 * CL_BITS;
    localparam int EXT_BITS  = 64;

    // saturate a wide operand at 2^DRAW_BITS, beyond any draw
    function automatic logic [CL_BITS-1:0] f_sat(input logic [EXT_BITS-1:0] x);
        logic [CL_BITS-1:0] v;
        if (x[EXT_BITS-1:DRAW_BITS] != '0) begin
            v = CL_BITS'(1) << DRAW_BITS;
        end else begin
            v = {1'b0, x[DRAW_BITS-1:0]};
        end
        return v;
    endfunction

    logic                 r_busy;
    logic                 r_seat;
    logic [DRAW_BITS-1:0] r_r;
    logic [IDX_BITS:0]    r_iss;
    logic                 r_s1_v;
    logic [IDX_BITS-1:0]  r_s1_idx;
    logic                 r_s2_v;
    logic [IDX_BITS-1:0]  r_s2_idx;
    logic                 r_s2_nz;
    logic [COUNT_BITS-1:0] r_s2_cnt;
    logic [P_BITS-1:0]    r_s2_term;
    t_walk_sts            r_sts;
    logic [IDX_BITS-1:0]  r_idx;
    logic [COUNT_BITS-1:0] r_cnt;

    logic [W_BITS-1:0]    disc_al;
    logic [SIZE_BITS-1:0] size;
    logic [W_BITS-1:0]    weight;
    logic [P_BITS-1:0]    term;
    logic                 hit;
    logic                 last;

    // discount aligned to the draw's fraction
    generate
        if (FRAC_BITS >= DISC_BITS) begin : g_disc_up
            assign disc_al = W_BITS'(i_disc) << (FRAC_BITS - DISC_BITS);
        end else begin : g_disc_dn
            assign disc_al = W_BITS'(i_disc >> (DISC_BITS - FRAC_BITS));
        end
    endgenerate

    // read issue, one entry a cycle
    assign o_rd_en   = r_busy && (r_iss < (IDX_BITS + 1)'(MAX_SIZE));
    assign o_rd_addr = r_iss[IDX_BITS-1:0];

    // weight and term of the entry coming out of the memory
    always_comb begin
        size = SIZE_BITS'(r_s1_idx) + SIZE_BITS'(1);
        if (r_seat) begin
            weight = (W_BITS'(size) << FRAC_BITS) - disc_al;
        end else begin
            weight = W_BITS'(size);
        end
        term = P_BITS'(f_sat(EXT_BITS'(i_rd_data))) * P_BITS'(f_sat(EXT_BITS'(weight)));
    end

    // draw against registered term
    assign hit  = r_s2_v && r_s2_nz && (P_BITS'(r_r) <= r_s2_term);
    assign last = r_s2_v && (r_s2_idx == IDX_BITS'(MAX_SIZE - 1));

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_sts  <= '0;
        end else begin
            r_sts.done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_s1_v <= 1'b0;
                r_s2_v <= 1'b0;
            end else if (r_busy) begin
                r_s1_v <= o_rd_en;
                r_s2_v <= r_s1_v;
                if (hit || last) begin
                    r_busy      <= 1'b0;
                    r_s1_v      <= 1'b0;
                    r_s2_v      <= 1'b0;
                    r_sts.done  <= 1'b1;
                    r_sts.found <= hit;
                end
            end else begin
                r_s1_v <= 1'b0;
                r_s2_v <= 1'b0;
            end
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_seat <= i_ctl.seat;
            r_r    <= i_r;
            r_iss  <= '0;
        end else if (r_busy) begin
            if (o_rd_en) begin
                r_iss <= r_iss + (IDX_BITS + 1)'(1);
            end
            if (r_s2_v && !hit) begin
                r_r <= r_r - DRAW_BITS'(r_s2_term);
            end
        end
        r_s1_idx  <= o_rd_addr;
        r_s2_idx  <= r_s1_idx;
        r_s2_cnt  <= i_rd_data;
        r_s2_nz   <= (i_rd_data != '0);
        r_s2_term <= term;
        if (hit) begin
            r_idx <= r_s2_idx;
            r_cnt <= r_s2_cnt;
        end
    end

    assign o_sts = r_sts;
    assign o_idx = r_idx;
    assign o_cnt = r_cnt;

endmodule

`default_nettype wire

/* hw/rtl/crp_table_histogram_sampler.sv */
`default_nettype none

// channel   direction  handshake          word
// input     in         i_valid / o_ready  i_op, i_draw
// output    out        o_valid / i_ready  o_new_size, o_customers, o_tables,
//                                         o_empty_res, o_error
// config    in         APB write/read     discount at any byte address
//
// seat and remove walk the histogram memory one entry a cycle through its read
// port. open reads the size-one entry and writes it back incremented.
// after reset a clearing pass writes every entry to zero, during which no
// input word is taken; config writes are taken at any time.
// one word is worked on at a time; a new word is taken while the result of
// the last one waits in the output register.

module crp_table_histogram_sampler #(
    parameter int MAX_SIZE   = crp_ths_pkg::DEF_MAX_SIZE,
    parameter int COUNT_BITS = crp_ths_pkg::DEF_COUNT_BITS,
    parameter int FRAC_BITS  = crp_ths_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [crp_ths_pkg::OP_BITS-1:0]       i_op,
    input  wire logic [crp_ths_pkg::DRAW_BITS-1:0]     i_draw,
    // output channel
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic      [$clog2(MAX_SIZE+1)-1:0]         o_new_size,
    output logic      [COUNT_BITS-1:0]                 o_customers,
    output logic      [COUNT_BITS-1:0]                 o_tables,
    output logic                                       o_empty_res,
    output logic                                       o_error,
    // config port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [crp_ths_pkg::PADDR_BITS-1:0]    paddr,
    input  wire logic [crp_ths_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [crp_ths_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                       pready
);
    import crp_ths_pkg::*;

    localparam int IDX_BITS  = $clog2(MAX_SIZE);
    localparam int SIZE_BITS = $clog2(MAX_SIZE + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_WR2   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]            r_state;
    logic [IDX_BITS-1:0]   r_clr;
    logic [DISC_BITS-1:0]  r_disc;
    logic [OP_BITS-1:0]    r_op;
    logic [IDX_BITS-1:0]   r_idx;
    logic [IDX_BITS-1:0]   r_inc_addr;
    logic [IDX_BITS-1:0]   r_dec_addr;
    logic [COUNT_BITS-1:0] r_dec_val;
    logic                  r_has_dec;
    logic                  r_err;
    logic [SIZE_BITS-1:0]  r_new_size;
    logic [COUNT_BITS-1:0] r_cust;
    logic [COUNT_BITS-1:0] r_tabs;

    logic                  r_out_v;
    logic [SIZE_BITS-1:0]  r_o_new_size;
    logic [COUNT_BITS-1:0] r_o_cust;
    logic [COUNT_BITS-1:0] r_o_tabs;
    logic                  r_o_empty;
    logic                  r_o_err;

    t_walk_ctl             walk_ctl;
    t_walk_sts             walk_sts;
    logic [DRAW_BITS-1:0]  walk_r;
    logic                  walk_rd_en;
    logic [IDX_BITS-1:0]   walk_rd_addr;
    logic [IDX_BITS-1:0]   walk_idx;
    logic [COUNT_BITS-1:0] walk_cnt;

    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [IDX_BITS-1:0]   ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    logic                  in_acc;
    logic                  out_free;
    logic                  cfg_wr;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_v || i_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc <= '0;
        end else if (cfg_wr && (paddr >> 2) == PADDR_BITS'(REG_DISCOUNT)) begin
            r_disc <= pwdata[DISC_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = APB_DATA_BITS'(r_disc);

    // walk start
    always_comb begin
        walk_ctl.start = in_acc && (i_op inside {OP_SEAT, OP_REMOVE});
        walk_ctl.seat  = (i_op == OP_SEAT);
        if (i_op == OP_SEAT) begin
            walk_r = i_draw;
        end else begin
            walk_r = i_draw >> FRAC_BITS;
        end
    end

    crp_ths_walk #(
        .MAX_SIZE   (MAX_SIZE),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_disc    (r_disc),
        .i_ctl     (walk_ctl),
        .i_r       (walk_r),
        .o_rd_en   (walk_rd_en),
        .o_rd_addr (walk_rd_addr),
        .i_rd_data (ram_rdata),
        .o_sts     (walk_sts),
        .o_idx     (walk_idx),
        .o_cnt     (walk_cnt)
    );

    // memory port selection
    always_comb begin
        ram_re    = walk_rd_en;
        ram_raddr = walk_rd_addr;
        if (r_state == S_RD) begin
            ram_re    = 1'b1;
            ram_raddr = r_inc_addr;
        end
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_CHK: begin
                ram_we    = (ram_rdata != '1);
                ram_waddr = r_inc_addr;
                ram_wdata = ram_rdata + COUNT_BITS'(1);
            end
            S_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = r_dec_addr;
                ram_wdata = r_dec_val;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    crp_ths_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready = (r_state == S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cust  <= '0;
            r_tabs  <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_BITS'(1);
                    if (r_clr == IDX_BITS'(MAX_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op       <= i_op;
                        r_err      <= 1'b0;
                        r_new_size <= '0;
                        case (i_op)
                            OP_SEAT, OP_REMOVE: begin
                                r_state <= S_WALK;
                            end
                            OP_OPEN: begin
                                r_has_dec  <= 1'b0;
                                r_inc_addr <= '0;
                                if (r_cust == '1 || r_tabs == '1) begin
                                    r_err   <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_err   <= 1'b1;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (walk_sts.done) begin
                        r_idx      <= walk_idx;
                        r_dec_addr <= walk_idx;
                        r_dec_val  <= walk_cnt - COUNT_BITS'(1);
                        r_has_dec  <= 1'b1;
                        if (!walk_sts.found) begin
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else if (r_op == OP_SEAT) begin
                            r_inc_addr <= walk_idx + IDX_BITS'(1);
                            if (walk_idx == IDX_BITS'(MAX_SIZE - 1) || r_cust == '1) begin
                                r_err   <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end else begin
                            r_inc_addr <= walk_idx - IDX_BITS'(1);
                            if (r_cust == '0 || (walk_idx == '0 && r_tabs == '0)) begin
                                r_err   <= 1'b1;
                                r_state <= S_DONE;
                            end else if (walk_idx == '0) begin
                                r_state <= S_WR2;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (ram_rdata == '1) begin
                        r_err   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_has_dec) begin
                        r_state <= S_WR2;
                    end else begin
                        // open a table of size one
                        r_cust     <= r_cust + COUNT_BITS'(1);
                        r_tabs     <= r_tabs + COUNT_BITS'(1);
                        r_new_size <= SIZE_BITS'(1);
                        r_state    <= S_DONE;
                    end
                end
                S_WR2: begin
                    if (r_op == OP_SEAT) begin
                        r_cust     <= r_cust + COUNT_BITS'(1);
                        r_new_size <= SIZE_BITS'(r_idx) + SIZE_BITS'(2);
                    end else begin
                        r_cust     <= r_cust - COUNT_BITS'(1);
                        r_new_size <= SIZE_BITS'(r_idx);
                        if (r_idx == '0) begin
                            r_tabs <= r_tabs - COUNT_BITS'(1);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_new_size <= r_err ? '0 : r_new_size;
            r_o_cust     <= r_cust;
            r_o_tabs     <= r_tabs;
            r_o_empty    <= (r_cust == '0);
            r_o_err      <= r_err;
        end
    end

    assign o_valid     = r_out_v;
    assign o_new_size  = r_o_new_size;
    assign o_customers = r_o_cust;
    assign o_tables    = r_o_tabs;
    assign o_empty_res = r_o_empty;
    assign o_error     = r_o_err;

endmodule

`default_nettype wire

/* hw/rtl/crp_ths_checker.sv */
`default_nettype none

module crp_ths_checker #(
    parameter int MAX_SIZE   = crp_ths_pkg::DEF_MAX_SIZE,
    parameter int COUNT_BITS = crp_ths_pkg::DEF_COUNT_BITS
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic [$clog2(MAX_SIZE+1)-1:0] o_new_size,
    input wire logic [COUNT_BITS-1:0]         o_customers,
    input wire logic [COUNT_BITS-1:0]         o_tables,
    input wire logic                          o_empty_res,
    input wire logic                          o_error
);

    // a stalled result word holds its size, totals and error flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_new_size) && $stable(o_customers)
            && $stable(o_tables) && $stable(o_error))
        else $error("result word changed while stalled");

    // refused operation reports no table
    a_err_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_new_size == '0)
        else $error("error word carries a table size");

    // empty flag follows the customer total
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_empty_res == (o_customers == '0))
        else $error("empty flag disagrees with customer total");

    // no tables means no customers
    a_no_tables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tables == '0 |-> o_empty_res)
        else $error("customers seated with no tables");

endmodule

bind crp_table_histogram_sampler crp_ths_checker #(
    .MAX_SIZE   (MAX_SIZE),
    .COUNT_BITS (COUNT_BITS)
) u_crp_ths_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_new_size  (o_new_size),
    .o_customers (o_customers),
    .o_tables    (o_tables),
    .o_empty_res (o_empty_res),
    .o_error     (o_error)
);

`default_nettype wire
